[hdl/kmd_pkg.sv]
// Shared types, codes and constants of the knob-to-mouse drag controller.
// Used by every module of the block; depends on nothing.
`default_nettype none

package kmd_pkg;

   localparam int SampleBitsDefault = 12;
   localparam int TotalBitsDefault  = 16;
   localparam int MaxResults        = 4;
   localparam int CsrIndexBits      = 2;
   localparam int CsrDataBits       = 13;
   localparam int RspDataBits       = 16;

   localparam logic [7:0]  PulseGapReset  = 8'd20;
   localparam logic [10:0] DebounceReset  = 11'd200;
   localparam logic [12:0] ReleaseReset   = 13'd1000;
   localparam logic [11:0] ThresholdReset = 12'd100;
   localparam logic [4:0]  ScaleReset     = 5'd10;

   localparam logic [15:0] CoefFb    = 16'd63504;
   localparam logic [9:0]  CoefIn    = 10'd1016;
   localparam int          ScaleStep = 200;
   localparam int          ScaleMax  = 31;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_PULSE_GAP = 2'd0,
      CSR_DEBOUNCE  = 2'd1,
      CSR_RELEASE   = 2'd2,
      CSR_THRESHOLD = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_EDGE = 1'b1
   } operation_type;

   typedef enum logic [1:0] {
      ACT_PRESS   = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_MOVE    = 2'd2
   } action_type;

   typedef struct packed {
      logic          valid;
      operation_type operation;
      logic          pin_a;
      logic          pin_b;
      logic          link_up;
      logic          mode_button;
   } req_ctrl_type;

   typedef struct packed {
      action_type        action;
      logic              use_right;
      logic signed [7:0] move_delta;
   } result_entry_type;

   typedef struct packed {
      result_entry_type [MaxResults-1:0] entry;
      logic [2:0]                        count;
      logic                              right_mode;
   } result_batch_type;

   // scale = 1 + sens/200, saturated at 31
   function automatic logic [4:0] scale_of(input logic [31:0] sens);
      int steps;
      steps = 0;
      for (int k = 1; k < ScaleMax; k++) begin
         if (sens >= 32'(ScaleStep * k)) begin
            steps = steps + 1;
         end
      end
      return 5'(steps + 1);
   endfunction

endpackage

`default_nettype wire

[hdl/knob_to_mouse_drag_controller_unit.sv]
// Top level of the knob-to-mouse drag controller: input slice, core and result queue.
// Depends on kmd_pkg, kmd_req_stage, kmd_core and kmd_rsp_queue.
//
//   channel  dir  ports              beat carries
//   req      in   req_t*             one tick or encoder edge
//   rsp      out  rsp_t*             one mouse action (tlast on the final one of an item)
//   csr      in   csr_*              one register write, index and data
//
// An accepted item is registered, then processed combinationally into a batch of 0..4 results.
// The first result beat is offered once the item has passed the input slice into the result
// queue; results leave at one beat per cycle while rsp_tready is high; an edge yields none.
// A new item is taken while the last beat of the previous batch is being delivered.
// Reset is synchronous and loads register and state defaults at once; no clearing pass.
// rsp_tready low holds the queue and, through it, the input slice.
`default_nettype none

module knob_to_mouse_drag_controller_unit import kmd_pkg::*; #(
   parameter int SAMPLE_BITS = SampleBitsDefault,
   parameter int TOTAL_BITS  = TotalBitsDefault
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   // pin_a, pin_b, link_up, mode_button, pot_sample, zero fill
   input  wire logic [((4 + SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,
   // operation
   input  wire logic                                      req_tuser,
   output logic                                           rsp_tvalid,
   input  wire logic                                      rsp_tready,
   // use_right, move_delta, right_mode, zero fill
   output logic [RspDataBits-1:0]                         rsp_tdata,
   // action
   output logic [1:0]                                     rsp_tuser,
   output logic                                           rsp_tlast,
   input  wire logic                                      csr_valid,
   output logic                                           csr_ready,
   input  wire logic [CsrIndexBits-1:0]                   csr_index,
   input  wire logic [CsrDataBits-1:0]                    csr_data
);

   localparam int ReqBits = ((4 + SAMPLE_BITS + 7) / 8) * 8;

   req_ctrl_type           ctrl;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   queue_ready;
   logic                   fire;
   result_batch_type       batch;

   kmd_req_stage #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .REQ_BITS    (ReqBits)
   ) u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (fire),
      .ctrl       (ctrl),
      .sample     (sample)
   );

   kmd_core #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TOTAL_BITS  (TOTAL_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .ctrl        (ctrl),
      .sample      (sample),
      .queue_ready (queue_ready),
      .fire        (fire),
      .batch       (batch)
   );

   kmd_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .batch      (batch),
      .ready      (queue_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[hdl/kmd_req_stage.sv]
// Input register slice of the drag controller.
// Depends on kmd_pkg for the control struct and operation codes.
`default_nettype none

module kmd_req_stage import kmd_pkg::*; #(
   parameter int SAMPLE_BITS = SampleBitsDefault,
   parameter int REQ_BITS    = ((4 + SampleBitsDefault + 7) / 8) * 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_BITS-1:0]    req_tdata,
   input  wire logic                   req_tuser,
   input  wire logic                   take,
   output req_ctrl_type                ctrl,
   output logic [SAMPLE_BITS-1:0]      sample
);

   logic                   valid_ff, valid_in;
   req_ctrl_type           ctrl_ff, ctrl_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                   accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in  = valid_ff;
      ctrl_in   = ctrl_ff;
      sample_in = sample_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in            = 1'b1;
         ctrl_in.operation   = operation_type'(req_tuser);
         ctrl_in.pin_a       = req_tdata[0];
         ctrl_in.pin_b       = req_tdata[1];
         ctrl_in.link_up     = req_tdata[2];
         ctrl_in.mode_button = req_tdata[3];
         sample_in           = req_tdata[4 +: SAMPLE_BITS];
      end
      ctrl_in.valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      ctrl_ff   <= ctrl_in;
      sample_ff <= sample_in;
   end

   always_comb begin
      ctrl       = ctrl_ff;
      ctrl.valid = valid_ff;
   end
   assign sample = sample_ff;

endmodule

`default_nettype wire

[hdl/kmd_core.sv]
// Control registers, controller state and the per-item update of the drag controller.
// Depends on kmd_pkg; feeds a batch of up to four results to kmd_rsp_queue.
`default_nettype none

module kmd_core import kmd_pkg::*; #(
   parameter int SAMPLE_BITS = SampleBitsDefault,
   parameter int TOTAL_BITS  = TotalBitsDefault
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CsrIndexBits-1:0] csr_index,
   input  wire logic [CsrDataBits-1:0]  csr_data,
   input  wire req_ctrl_type            ctrl,
   input  wire logic [SAMPLE_BITS-1:0]  sample,
   input  wire logic                    queue_ready,
   output logic                         fire,
   output result_batch_type             batch
);

   localparam int FiltBits = SAMPLE_BITS + 16;
   localparam int AccBits  = FiltBits + 17;
   localparam logic signed [TOTAL_BITS-1:0] TotMax = {1'b0, {(TOTAL_BITS-1){1'b1}}};
   localparam logic signed [TOTAL_BITS-1:0] TotMin = {1'b1, {(TOTAL_BITS-1){1'b0}}};
   localparam logic signed [TOTAL_BITS:0]   Lim    = (TOTAL_BITS+1)'(127);

   logic [7:0]  gap_ff, gap_in;
   logic [10:0] debounce_ff, debounce_in;
   logic [12:0] release_ff, release_in;
   logic [11:0] thr_ff, thr_in;

   logic [7:0]                    edge_ff, edge_in;
   logic [12:0]                   rot_ff, rot_in;
   logic [10:0]                   press_ff, press_in;
   logic signed [TOTAL_BITS-1:0]  net_ff, net_in;
   logic signed [TOTAL_BITS-1:0]  total_ff, total_in;
   logic                          pend_ff, pend_in;
   logic                          held_ff, held_in;
   logic                          mode_ff, mode_in;
   logic [4:0]                    scale_ff, scale_in;
   logic [FiltBits-1:0]           filt_ff, filt_in;
   logic [SAMPLE_BITS-1:0]        prev_ff, prev_in;
   logic [SAMPLE_BITS-1:0]        applied_ff, applied_in;

   logic [FiltBits+15:0]     fb_prod;
   logic [SAMPLE_BITS:0]     in_sum;
   logic [SAMPLE_BITS+10:0]  in_prod;
   logic [AccBits-1:0]       acc;
   logic [FiltBits:0]        y_wide;
   logic [FiltBits-1:0]      y_sat;
   logic [SAMPLE_BITS-1:0]   sens, diff;

   function automatic logic signed [TOTAL_BITS-1:0] sat_add(
      input logic signed [TOTAL_BITS-1:0] a,
      input logic signed [7:0]            b
   );
      logic signed [TOTAL_BITS:0] s;
      s = {a[TOTAL_BITS-1], a} + (TOTAL_BITS+1)'(b);
      if (s[TOTAL_BITS] != s[TOTAL_BITS-1]) begin
         return s[TOTAL_BITS] ? TotMin : TotMax;
      end
      return s[TOTAL_BITS-1:0];
   endfunction

   assign csr_ready = 1'b1;
   assign fire      = ctrl.valid && queue_ready;

   always_comb begin
      gap_in      = gap_ff;
      debounce_in = debounce_ff;
      release_in  = release_ff;
      thr_in      = thr_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_PULSE_GAP: gap_in      = csr_data[7:0];
            CSR_DEBOUNCE:  debounce_in = csr_data[10:0];
            CSR_RELEASE:   release_in  = csr_data[12:0];
            CSR_THRESHOLD: thr_in      = csr_data[11:0];
            default:       gap_in      = gap_ff;
         endcase
      end
   end

   // sensitivity low-pass: y = (0.969*y1 + 0.0155*(x + x1)) in Q.16
   always_comb begin
      fb_prod = (FiltBits+16)'(filt_ff) * (FiltBits+16)'(CoefFb);
      in_sum  = (SAMPLE_BITS+1)'(sample) + (SAMPLE_BITS+1)'(prev_ff);
      in_prod = (SAMPLE_BITS+11)'(in_sum) * (SAMPLE_BITS+11)'(CoefIn);
      acc     = AccBits'(fb_prod) + (AccBits'(in_prod) << 16);
      y_wide  = acc[AccBits-1:16];
      y_sat   = y_wide[FiltBits] ? {FiltBits{1'b1}} : y_wide[FiltBits-1:0];
      sens    = y_sat[FiltBits-1:16];
      diff    = (sens > applied_ff) ? sens - applied_ff : applied_ff - sens;
   end

   always_comb begin
      logic                       rel;
      logic signed [TOTAL_BITS:0] neg;
      logic signed [7:0]          ret, delta;
      logic signed [TOTAL_BITS-1:0] base;
      logic [2:0]                 n;

      edge_in    = edge_ff;
      rot_in     = rot_ff;
      press_in   = press_ff;
      net_in     = net_ff;
      total_in   = total_ff;
      pend_in    = pend_ff;
      held_in    = held_ff;
      mode_in    = mode_ff;
      scale_in   = scale_ff;
      filt_in    = filt_ff;
      prev_in    = prev_ff;
      applied_in = applied_ff;
      batch      = '0;
      n          = 3'd0;
      rel        = 1'b0;
      neg        = '0;
      ret        = '0;
      delta      = '0;
      base       = '0;

      if (ctrl.operation == OP_EDGE) begin
         if (edge_ff >= gap_ff) begin
            pend_in = 1'b1;
            net_in  = sat_add(net_ff, (ctrl.pin_a != ctrl.pin_b) ? 8'sd1 : -8'sd1);
         end
         edge_in = '0;
      end else begin
         edge_in  = (edge_ff == '1) ? edge_ff : edge_ff + 8'd1;
         rot_in   = (rot_ff == '1) ? rot_ff : rot_ff + 13'd1;
         press_in = (press_ff == '1) ? press_ff : press_ff + 11'd1;

         rel = held_ff && (rot_in > release_ff);
         if (rel) begin
            held_in = 1'b0;
            batch.entry[n[1:0]] = '{action: ACT_RELEASE, use_right: 1'b0, move_delta: 8'sd0};
            n = n + 3'd1;
            if (total_ff != '0) begin
               neg = -{total_ff[TOTAL_BITS-1], total_ff};
               if (neg > Lim) begin
                  ret = 8'sd127;
               end else if (neg < -Lim) begin
                  ret = -8'sd127;
               end else begin
                  ret = neg[7:0];
               end
               batch.entry[n[1:0]] = '{action: ACT_MOVE, use_right: 1'b0, move_delta: ret};
               n = n + 3'd1;
               total_in = '0;
            end
         end

         if (pend_ff) begin
            pend_in = 1'b0;
            net_in  = '0;
            base    = total_in;
            if (!held_in) begin
               batch.entry[n[1:0]] = '{action: ACT_PRESS, use_right: mode_ff,
                                       move_delta: 8'sd0};
               n       = n + 3'd1;
               held_in = 1'b1;
               base    = '0;
            end
            delta    = net_ff[TOTAL_BITS-1] ? $signed({3'b0, scale_ff})
                                            : -$signed({3'b0, scale_ff});
            total_in = sat_add(base, delta);
            batch.entry[n[1:0]] = '{action: ACT_MOVE, use_right: 1'b0, move_delta: delta};
            n      = n + 3'd1;
            rot_in = '0;
         end

         if (ctrl.link_up) begin
            if (ctrl.mode_button) begin
               if (press_in > debounce_ff) begin
                  mode_in = !mode_ff;
               end
               press_in = '0;
            end
            filt_in = y_sat;
            prev_in = sample;
            if (32'(diff) > 32'(thr_ff)) begin
               scale_in   = scale_of(32'(sens));
               applied_in = sens;
            end
         end
      end

      batch.count      = n;
      batch.right_mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff      <= PulseGapReset;
         debounce_ff <= DebounceReset;
         release_ff  <= ReleaseReset;
         thr_ff      <= ThresholdReset;
         edge_ff     <= '1;
         rot_ff      <= '0;
         press_ff    <= '1;
         net_ff      <= '0;
         total_ff    <= '0;
         pend_ff     <= 1'b0;
         held_ff     <= 1'b0;
         mode_ff     <= 1'b1;
         scale_ff    <= ScaleReset;
         filt_ff     <= '0;
         prev_ff     <= '0;
         applied_ff  <= '0;
      end else begin
         gap_ff      <= gap_in;
         debounce_ff <= debounce_in;
         release_ff  <= release_in;
         thr_ff      <= thr_in;
         if (fire) begin
            edge_ff    <= edge_in;
            rot_ff     <= rot_in;
            press_ff   <= press_in;
            net_ff     <= net_in;
            total_ff   <= total_in;
            pend_ff    <= pend_in;
            held_ff    <= held_in;
            mode_ff    <= mode_in;
            scale_ff   <= scale_in;
            filt_ff    <= filt_in;
            prev_ff    <= prev_in;
            applied_ff <= applied_in;
         end
      end
   end

   a_served_rotation_holds_button: assert property (@(posedge clock) disable iff (reset)
      fire && ctrl.operation == OP_TICK && pend_ff |=> held_ff && !pend_ff)
      else $error("served rotation left button released or rotation pending");

   a_edge_restarts_gap: assert property (@(posedge clock) disable iff (reset)
      fire && ctrl.operation == OP_EDGE |=> edge_ff == '0 && batch.count == 3'd0
      || edge_ff == '0)
      else $error("edge beat did not restart the gap timer");

   a_mode_changes_on_linked_press: assert property (@(posedge clock) disable iff (reset)
      !$stable(mode_ff) && !$past(reset) |->
         $past(fire && ctrl.operation == OP_TICK && ctrl.link_up && ctrl.mode_button))
      else $error("mode changed without a linked button press");

endmodule

`default_nettype wire

[hdl/kmd_rsp_queue.sv]
// Result queue of the drag controller: holds one batch and shifts it out one beat at a time.
// Depends on kmd_pkg for the batch struct and action codes.
`default_nettype none

module kmd_rsp_queue import kmd_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire result_batch_type       batch,
   output logic                        ready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RspDataBits-1:0]      rsp_tdata,
   output logic [1:0]                  rsp_tuser,
   output logic                        rsp_tlast
);

   result_entry_type [MaxResults-1:0] entry_ff, entry_in;
   logic [2:0]                        cnt_ff, cnt_in;
   logic                              mode_ff, mode_in;
   logic                              pop;

   assign rsp_tvalid = cnt_ff != 3'd0;
   assign pop        = rsp_tvalid && rsp_tready;
   assign ready      = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_tready);

   always_comb begin
      entry_in = entry_ff;
      cnt_in   = cnt_ff;
      mode_in  = mode_ff;
      if (load) begin
         entry_in = batch.entry;
         cnt_in   = batch.count;
         mode_in  = batch.right_mode;
      end else if (pop) begin
         for (int i = 0; i < MaxResults - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
         entry_in[MaxResults-1] = '0;
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      entry_ff <= entry_in;
      mode_ff  <= mode_in;
   end

   assign rsp_tuser = entry_ff[0].action;
   assign rsp_tlast = cnt_ff == 3'd1;
   assign rsp_tdata = {6'b0, mode_ff, entry_ff[0].move_delta, entry_ff[0].use_right};

endmodule

`default_nettype wire
